>>> rtl/core/mscu_pkg.sv
package mscu_pkg;

  typedef enum logic {
    F_IDLE,
    F_WORK
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_DIV,
    B_MULX,
    B_ADDX,
    B_MULZ,
    B_ADDZ,
    B_WRITE
  } back_state_t;

  // cell edges
  localparam logic [1:0] EDGE_S = 2'd0;
  localparam logic [1:0] EDGE_E = 2'd1;
  localparam logic [1:0] EDGE_N = 2'd2;
  localparam logic [1:0] EDGE_W = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Z    = 3'd3;
  localparam logic [2:0] REG_CELL_SIZE   = 3'd4;
  localparam logic [2:0] REG_SEA_LEVEL   = 3'd5;

  localparam int TBITS = 17;
  localparam logic [TBITS-1:0] T_ZERO = 17'd0;
  localparam logic [TBITS-1:0] T_HALF = 17'd32768;
  localparam logic [TBITS-1:0] T_ONE  = 17'd65536;
  localparam int QBITS = 16;
  localparam int OUT_BITS = 48;

  localparam logic [3:0] CODE_NONE = 4'd0;
  localparam logic [3:0] CODE_ALL  = 4'd15;
  localparam logic [3:0] CODE_SADDLE_A = 4'd5;
  localparam logic [3:0] CODE_SADDLE_B = 4'd10;

  // number of segments in a cell
  function automatic logic [1:0] seg_count(input logic [3:0] code);
    logic [1:0] c;
    c = 2'd1;
    if (code == CODE_NONE || code == CODE_ALL) c = 2'd0;
    else if (code == CODE_SADDLE_A || code == CODE_SADDLE_B) c = 2'd2;
    return c;
  endfunction

  // start and end edge of segment k, {start, end}
  function automatic logic [3:0] seg_edges(input logic [3:0] code, input logic k);
    logic [3:0] e;
    unique case (code)
      4'd1:  e = {EDGE_W, EDGE_S};
      4'd2:  e = {EDGE_S, EDGE_E};
      4'd3:  e = {EDGE_W, EDGE_E};
      4'd4:  e = {EDGE_E, EDGE_N};
      4'd5:  e = k ? {EDGE_E, EDGE_N} : {EDGE_W, EDGE_S};
      4'd6:  e = {EDGE_S, EDGE_N};
      4'd7:  e = {EDGE_W, EDGE_N};
      4'd8:  e = {EDGE_N, EDGE_W};
      4'd9:  e = {EDGE_N, EDGE_S};
      4'd10: e = k ? {EDGE_N, EDGE_W} : {EDGE_S, EDGE_E};
      4'd11: e = {EDGE_N, EDGE_E};
      4'd12: e = {EDGE_E, EDGE_W};
      4'd13: e = {EDGE_E, EDGE_S};
      4'd14: e = {EDGE_S, EDGE_W};
      default: e = {EDGE_S, EDGE_S};
    endcase
    return e;
  endfunction

endpackage

>>> rtl/core/marching_squares_contour_unit.sv
// marching squares isoline unit: height samples enter in raster order, one row after
// another, and each sample that closes a cell yields zero, one or two contour segments
// in world coordinates. the front end takes a sample by a line store read, then a
// classify and write back. the back end fetches the job for the first segment of a cell,
// then works out two endpoints for each segment, each with a restoring divide for the edge
// fraction when it is not trivial, and x and z through one shared multiply-add. a two-entry
// queue between the two parts and an output register let either side stall on its own
module marching_squares_contour_unit import mscu_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] height_sample,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [OUT_BITS-1:0]    start_x,
  output logic signed [OUT_BITS-1:0]    start_z,
  output logic signed [OUT_BITS-1:0]    end_x,
  output logic signed [OUT_BITS-1:0]    end_z,
  output logic                          last_of_cell,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int JOB_BITS = 4 * SAMPLE_BITS + 4 + CW + 16;

  logic [10:0]        grid_width;
  logic [15:0]        grid_height;
  logic signed [23:0] origin_cell_x;
  logic signed [23:0] origin_cell_z;
  logic [15:0]        cell_size;
  logic signed [23:0] sea_level;

  logic [2:0]          reg_idx;
  logic                cfg_wr;
  logic                job_push;
  logic                job_full;
  logic                job_pop;
  logic                job_empty;
  logic [JOB_BITS-1:0] job_in;
  logic [JOB_BITS-1:0] job_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= 11'd1024;
      grid_height   <= 16'd1024;
      origin_cell_x <= '0;
      origin_cell_z <= '0;
      cell_size     <= 16'd256;
      sea_level     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:  grid_width    <= pwdata[10:0];
        REG_GRID_HEIGHT: grid_height   <= pwdata[15:0];
        REG_ORIGIN_X:    origin_cell_x <= pwdata[23:0];
        REG_ORIGIN_Z:    origin_cell_z <= pwdata[23:0];
        REG_CELL_SIZE:   cell_size     <= pwdata[15:0];
        REG_SEA_LEVEL:   sea_level     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_WIDTH:  prdata = {21'd0, grid_width};
      REG_GRID_HEIGHT: prdata = {16'd0, grid_height};
      REG_ORIGIN_X:    prdata = {8'd0, origin_cell_x};
      REG_ORIGIN_Z:    prdata = {8'd0, origin_cell_z};
      REG_CELL_SIZE:   prdata = {16'd0, cell_size};
      REG_SEA_LEVEL:   prdata = {8'd0, sea_level};
      default:         prdata = 32'd0;
    endcase
  end

  mscu_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CW(CW),
    .JOB_BITS(JOB_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .height_sample(height_sample),
    .full(full),
    .grid_width(grid_width),
    .grid_height(grid_height),
    .sea_level(sea_level),
    .job_push(job_push),
    .job_data(job_in),
    .job_full(job_full)
  );

  mscu_fifo #(
    .WIDTH(JOB_BITS)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(job_push),
    .wdata(job_in),
    .full(job_full),
    .pop(job_pop),
    .rdata(job_out),
    .empty(job_empty)
  );

  mscu_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CW(CW),
    .JOB_BITS(JOB_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .job_data(job_out),
    .job_empty(job_empty),
    .job_pop(job_pop),
    .origin_cell_x(origin_cell_x),
    .origin_cell_z(origin_cell_z),
    .cell_size(cell_size),
    .sea_level(sea_level),
    .empty(empty),
    .pop(pop),
    .start_x(start_x),
    .start_z(start_z),
    .end_x(end_x),
    .end_z(end_z),
    .last_of_cell(last_of_cell)
  );

endmodule

>>> rtl/core/mscu_fifo.sv
module mscu_fifo import mscu_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

endmodule

>>> rtl/core/mscu_front.sv
module mscu_front import mscu_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int CW          = 10,
  parameter int JOB_BITS    = 4 * SAMPLE_BITS + 4 + CW + 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] height_sample,
  output logic                          full,
  input  logic [10:0]                   grid_width,
  input  logic [15:0]                   grid_height,
  input  logic signed [23:0]            sea_level,
  output logic                          job_push,
  output logic [JOB_BITS-1:0]           job_data,
  input  logic                          job_full
);

  localparam int WW = CW + 1;
  localparam int HW = ((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24) + 2;
  localparam logic [16:0] MAXW = 17'(MAX_WIDTH);

  front_state_t state, state_next;

  logic signed [SAMPLE_BITS-1:0] row_store [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] above;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] left_above_sample;
  logic [CW-1:0] column_count;
  logic [15:0]   row_count;
  logic [CW-1:0] col;
  logic [15:0]   row;

  logic [16:0]   gw_ext;
  logic [WW-1:0] we;
  logic [15:0]   eh;
  logic          wrap_col;
  logic [16:0]   row_inc;
  logic [CW-1:0] col_n;
  logic [15:0]   row_n;
  logic          accept;
  logic          advance;
  logic [3:0]    code;
  logic          emit;
  logic [WW-1:0] col_plus;
  logic [16:0]   row_plus;
  logic signed [HW-1:0] sea_e;

  assign gw_ext = {6'd0, grid_width};
  always_comb begin
    we = WW'(gw_ext);
    if (gw_ext > MAXW) we = WW'(MAXW);
    else if (grid_width == 11'd0) we = WW'(1);
  end
  assign eh = (grid_height == 16'd0) ? 16'd1 : grid_height;

  // start a new row or grid if the configuration moved under the counters
  assign wrap_col = ({1'b0, column_count} >= we);
  assign row_inc  = {1'b0, row_count} + {16'd0, wrap_col};
  assign col_n    = wrap_col ? '0 : column_count;
  assign row_n    = (row_inc >= {1'b0, eh}) ? 16'd0 : row_inc[15:0];

  assign full   = (state != F_IDLE);
  assign accept = push && !full;

  assign sea_e = HW'(sea_level);
  assign code = {(HW'(left_sample) > sea_e), (HW'(sample) > sea_e),
                 (HW'(above) > sea_e), (HW'(left_above_sample) > sea_e)};
  assign emit = (we >= WW'(2)) && (eh >= 16'd2) && (col != '0) && (row != 16'd0)
                && (seg_count(code) != 2'd0);

  assign job_data = {left_above_sample, above, sample, left_sample, code,
                     col - CW'(1), row - 16'd1};

  assign col_plus = {1'b0, col} + WW'(1);
  assign row_plus = {1'b0, row} + 17'd1;

  always_comb begin
    state_next = state;
    job_push   = 1'b0;
    advance    = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (accept) state_next = F_WORK;
      end
      F_WORK: begin
        if (!(emit && job_full)) begin
          job_push   = emit;
          advance    = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= F_IDLE;
      column_count      <= '0;
      row_count         <= '0;
      left_sample       <= '0;
      left_above_sample <= '0;
    end else begin
      state <= state_next;
      if (advance) begin
        left_above_sample <= above;
        left_sample       <= sample;
        if (col_plus >= we) begin
          column_count <= '0;
          row_count    <= (row_plus >= {1'b0, eh}) ? 16'd0 : row_plus[15:0];
        end else begin
          column_count <= col_plus[CW-1:0];
          row_count    <= row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= height_sample;
      col    <= col_n;
      row    <= row_n;
      above  <= row_store[col_n];
    end
    if (advance) row_store[col] <= sample;
  end

endmodule

>>> rtl/core/mscu_back.sv
module mscu_back import mscu_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int CW          = 10,
  parameter int JOB_BITS    = 4 * SAMPLE_BITS + 4 + CW + 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [JOB_BITS-1:0]        job_data,
  input  logic                       job_empty,
  output logic                       job_pop,
  input  logic signed [23:0]         origin_cell_x,
  input  logic signed [23:0]         origin_cell_z,
  input  logic [15:0]                cell_size,
  input  logic signed [23:0]         sea_level,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [OUT_BITS-1:0] start_x,
  output logic signed [OUT_BITS-1:0] start_z,
  output logic signed [OUT_BITS-1:0] end_x,
  output logic signed [OUT_BITS-1:0] end_z,
  output logic                       last_of_cell
);

  localparam int HW = ((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24) + 2;
  localparam int S  = SAMPLE_BITS;

  back_state_t state, state_next;

  logic signed [S-1:0] sw, se, ne, nw;
  logic [3:0]    code;
  logic [CW-1:0] gx;
  logic [15:0]   gz;
  logic          k;
  logic          j;
  logic [TBITS-1:0] t;
  logic [HW-1:0] rem;
  logic [HW-1:0] dv;
  logic [QBITS-1:0] q;
  logic [3:0]    cnt;
  logic signed [42:0] prod_hi;
  logic [32:0]   prod_lo;
  logic signed [OUT_BITS-1:0] px0, pz0, px1, pz1;
  logic          out_valid;

  logic [3:0]    edges;
  logic [1:0]    cur_edge;
  logic signed [S-1:0] h0, h1;
  logic signed [HW-1:0] d, n, ad, an;
  logic [HW:0]   rem2;
  logic          sel_x;
  logic [16:0]   g;
  logic [TBITS-1:0] tsel;
  logic signed [23:0] org;
  logic signed [25:0] base;
  logic signed [43:0] coord;
  logic          load;

  assign edges    = seg_edges(code, k);
  assign cur_edge = j ? edges[1:0] : edges[3:2];
  assign empty    = !out_valid;

  always_comb begin
    unique case (cur_edge)
      EDGE_S: begin h0 = sw; h1 = se; end
      EDGE_E: begin h0 = se; h1 = ne; end
      EDGE_N: begin h0 = nw; h1 = ne; end
      default: begin h0 = sw; h1 = nw; end
    endcase
  end

  assign d  = HW'(h1) - HW'(h0);
  assign n  = HW'(sea_level) - HW'(h0);
  assign ad = d[HW-1] ? -d : d;
  assign an = d[HW-1] ? -n : n;
  assign rem2 = {rem, 1'b0};

  // shared multiplier operands: x coordinate in MULX, z in MULZ
  assign sel_x = (state == B_MULX);
  always_comb begin
    if (sel_x) begin
      org  = origin_cell_x;
      g    = (cur_edge == EDGE_E) ? 17'({1'b0, gx} + (CW+1)'(1)) : 17'(gx);
      tsel = (cur_edge == EDGE_S || cur_edge == EDGE_N) ? t : T_ZERO;
    end else begin
      org  = origin_cell_z;
      g    = (cur_edge == EDGE_N) ? ({1'b0, gz} + 17'd1) : {1'b0, gz};
      tsel = (cur_edge == EDGE_E || cur_edge == EDGE_W) ? t : T_ZERO;
    end
  end
  assign base  = 26'(org) + $signed({9'd0, g});
  assign coord = 44'(prod_hi) + $signed({27'd0, prod_lo[32:16]});

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    load       = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = B_PREP;
        end
      end
      B_PREP: begin
        if (d == '0 || $signed(an) <= 0 || $signed(an) >= $signed(ad)) state_next = B_MULX;
        else state_next = B_DIV;
      end
      B_DIV:  if (cnt == 4'd15) state_next = B_MULX;
      B_MULX: state_next = B_ADDX;
      B_ADDX: state_next = B_MULZ;
      B_MULZ: state_next = B_ADDZ;
      B_ADDZ: state_next = j ? B_WRITE : B_PREP;
      B_WRITE: begin
        if (!out_valid || pop) begin
          load = 1'b1;
          state_next = (k == 1'b1 || seg_count(code) != 2'd2) ? B_IDLE : B_PREP;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      k         <= 1'b0;
      j         <= 1'b0;
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (job_pop) begin
        k <= 1'b0;
        j <= 1'b0;
      end else if (state == B_ADDZ) begin
        j <= !j;
      end else if (load) begin
        k <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) {sw, se, ne, nw, code, gx, gz} <= job_data;
    if (state == B_PREP) begin
      rem <= an;
      dv  <= ad;
      cnt <= 4'd0;
      if (d == '0) t <= T_HALF;
      else if ($signed(an) <= 0) t <= T_ZERO;
      else if ($signed(an) >= $signed(ad)) t <= T_ONE;
    end
    if (state == B_DIV) begin
      // one restoring step per cycle
      if (rem2 >= {1'b0, dv}) begin
        rem <= HW'(rem2 - {1'b0, dv});
        q   <= {q[QBITS-2:0], 1'b1};
      end else begin
        rem <= rem2[HW-1:0];
        q   <= {q[QBITS-2:0], 1'b0};
      end
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) t <= {1'b0, q[QBITS-2:0], (rem2 >= {1'b0, dv})};
    end
    if (state == B_MULX || state == B_MULZ) begin
      prod_hi <= base * $signed({1'b0, cell_size});
      prod_lo <= tsel * cell_size;
    end
    if (state == B_ADDX) begin
      if (j) px1 <= OUT_BITS'(coord);
      else px0 <= OUT_BITS'(coord);
    end
    if (state == B_ADDZ) begin
      if (j) pz1 <= OUT_BITS'(coord);
      else pz0 <= OUT_BITS'(coord);
    end
    if (load) begin
      start_x      <= px0;
      start_z      <= pz0;
      end_x        <= px1;
      end_z        <= pz1;
      last_of_cell <= (k == 1'b1 || seg_count(code) != 2'd2);
    end
  end

endmodule
